// ----- hw/rtl/gls_pkg.sv -----
// Shared types and constants of the gate lane sequencer.
package gls_pkg;

    localparam int unsigned SENSOR_COUNT = 4;
    localparam int unsigned DIST_W       = 16;
    localparam int unsigned COUNT_W      = 8;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned PULSE_W      = 16;
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned IN_DATA_W    = 96;
    localparam int unsigned OUT_DATA_W   = 40;

    typedef enum logic [2:0] {
        PHASE_IDLE         = 3'd0,
        PHASE_ENTRY_OPEN   = 3'd1,
        PHASE_ENTRY_CLOSED = 3'd2,
        PHASE_EXIT_OPEN    = 3'd3,
        PHASE_EXIT_CLOSED  = 3'd4
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIST_THRESHOLD = 3'd0,
        CFG_CONFIRM_COUNT  = 3'd1,
        CFG_LANE_TIMEOUT   = 3'd2,
        CFG_EXIT_SETTLE    = 3'd3,
        CFG_PULSE_CLOSED   = 3'd4,
        CFG_PULSE_OPEN     = 3'd5
    } cfg_addr_t;

    localparam logic [DIST_W-1:0]  RST_DIST_THRESHOLD = 16'd20;
    localparam logic [COUNT_W-1:0] RST_CONFIRM_COUNT  = 8'd3;
    localparam logic [TIME_W-1:0]  RST_LANE_TIMEOUT   = 32'd5000;
    localparam logic [TIME_W-1:0]  RST_EXIT_SETTLE    = 32'd3000;
    localparam logic [PULSE_W-1:0] RST_PULSE_CLOSED   = 16'd500;
    localparam logic [PULSE_W-1:0] RST_PULSE_OPEN     = 16'd1500;

endpackage

// ----- hw/rtl/gate_lane_sequencer_core.sv -----
// Top level of the gate lane sequencer: sensor confirm counters and lane phase control.
// Data path: a request is held in the input register, and its result is written to the
// result register once the output side can take it.
// Throughput: one request per cycle while the output is taken; a stalled output holds the input.
// Reset: rst_n clears asynchronously the phase, counters, gate flags, lock, tick
// and the configuration registers to their default values.
module gate_lane_sequencer_core
    import gls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // dist_entry, dist_inside, dist_before_exit, dist_exit, now_ms
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // entry_pulse, exit_pulse, lane_phase, exit_sensor_locked, active_mask
    output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    // Configuration registers.
    logic [DIST_W-1:0]  dist_threshold_reg;
    logic [COUNT_W-1:0] confirm_count_reg;
    logic [TIME_W-1:0]  lane_timeout_reg;
    logic [TIME_W-1:0]  exit_settle_reg;
    logic [PULSE_W-1:0] pulse_closed_reg;
    logic [PULSE_W-1:0] pulse_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_threshold_reg <= RST_DIST_THRESHOLD;
            confirm_count_reg  <= RST_CONFIRM_COUNT;
            lane_timeout_reg   <= RST_LANE_TIMEOUT;
            exit_settle_reg    <= RST_EXIT_SETTLE;
            pulse_closed_reg   <= RST_PULSE_CLOSED;
            pulse_open_reg     <= RST_PULSE_OPEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DIST_THRESHOLD: dist_threshold_reg <= cfg_data[DIST_W-1:0];
                CFG_CONFIRM_COUNT:  confirm_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_LANE_TIMEOUT:   lane_timeout_reg   <= cfg_data[TIME_W-1:0];
                CFG_EXIT_SETTLE:    exit_settle_reg    <= cfg_data[TIME_W-1:0];
                CFG_PULSE_CLOSED:   pulse_closed_reg   <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_OPEN:     pulse_open_reg     <= cfg_data[PULSE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register and handshake.
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // Sensor confirm counters.
    logic [COUNT_W-1:0]      count_reg  [SENSOR_COUNT];
    logic [COUNT_W-1:0]      count_next [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] active;
    logic [DIST_W-1:0]       dist_cm    [SENSOR_COUNT];
    logic [TIME_W-1:0]       now_ms;

    always_comb
    begin
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            dist_cm[i] = in_data_reg[i*DIST_W +: DIST_W];
            if (dist_cm[i] != '0 && dist_cm[i] <= dist_threshold_reg)
            begin
                if (count_reg[i] < confirm_count_reg)
                    count_next[i] = count_reg[i] + COUNT_W'(1);
                else
                    count_next[i] = count_reg[i];
            end
            else
            begin
                count_next[i] = '0;
            end
            active[i] = (count_next[i] >= confirm_count_reg);
        end
    end

    assign now_ms = in_data_reg[SENSOR_COUNT*DIST_W +: TIME_W];

    // Lane phase sequencer.
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TIME_W-1:0]  start_ms_reg;
    logic [TIME_W-1:0]  start_ms_next;
    logic               lock_reg;
    logic               lock_next;
    logic               entry_open_reg;
    logic               entry_open_next;
    logic               exit_open_reg;
    logic               exit_open_next;
    logic [TIME_W-1:0]  elapsed;
    logic               lane_expired;
    logic               settle_expired;
    logic               exit_ready;

    // Elapsed time wraps modulo the tick width.
    assign elapsed        = now_ms - start_ms_reg;
    assign lane_expired   = (elapsed > lane_timeout_reg);
    assign settle_expired = (elapsed > exit_settle_reg);
    assign exit_ready     = !lock_reg && active[3];

    always_comb
    begin
        unique case (phase_reg)
            PHASE_ENTRY_OPEN:
                phase_next = active[1] ? PHASE_ENTRY_CLOSED :
                             (lane_expired ? PHASE_IDLE : PHASE_ENTRY_OPEN);
            PHASE_ENTRY_CLOSED:
                phase_next = active[2] ? PHASE_EXIT_OPEN :
                             (lane_expired ? PHASE_IDLE : PHASE_ENTRY_CLOSED);
            PHASE_EXIT_OPEN:
                phase_next = exit_ready ? PHASE_EXIT_CLOSED :
                             (lane_expired ? PHASE_IDLE : PHASE_EXIT_OPEN);
            PHASE_EXIT_CLOSED:
                phase_next = (!active[3] || settle_expired) ? PHASE_IDLE
                                                            : PHASE_EXIT_CLOSED;
            default:
                phase_next = active[0] ? PHASE_ENTRY_OPEN : PHASE_IDLE;
        endcase
    end

    always_comb
    begin
        start_ms_next   = start_ms_reg;
        lock_next       = lock_reg;
        entry_open_next = entry_open_reg;
        exit_open_next  = exit_open_reg;
        unique case (phase_reg)
            PHASE_ENTRY_OPEN:
            begin
                if (active[1])
                begin
                    entry_open_next = 1'b0;
                    start_ms_next   = now_ms;
                end
                else if (lane_expired)
                begin
                    entry_open_next = 1'b0;
                    lock_next       = 1'b0;
                end
            end
            PHASE_ENTRY_CLOSED:
            begin
                if (active[2])
                begin
                    exit_open_next = 1'b1;
                    lock_next      = 1'b0;
                    start_ms_next  = now_ms;
                end
                else if (lane_expired)
                begin
                    lock_next = 1'b0;
                end
            end
            PHASE_EXIT_OPEN:
            begin
                if (exit_ready)
                begin
                    exit_open_next = 1'b0;
                    start_ms_next  = now_ms;
                end
                else if (lane_expired)
                begin
                    exit_open_next = 1'b0;
                end
            end
            PHASE_EXIT_CLOSED:
            begin
            end
            default:
            begin
                if (active[0])
                begin
                    entry_open_next = 1'b1;
                    lock_next       = 1'b1;
                    start_ms_next   = now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_IDLE;
            start_ms_reg   <= '0;
            lock_reg       <= 1'b0;
            entry_open_reg <= 1'b0;
            exit_open_reg  <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            start_ms_reg   <= start_ms_next;
            lock_reg       <= lock_next;
            entry_open_reg <= entry_open_next;
            exit_open_reg  <= exit_open_next;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Result register.
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [PULSE_W-1:0]    entry_pulse;
    logic [PULSE_W-1:0]    exit_pulse;

    assign entry_pulse   = entry_open_next ? pulse_open_reg : pulse_closed_reg;
    assign exit_pulse    = exit_open_next ? pulse_open_reg : pulse_closed_reg;
    assign out_data_next = {active, lock_next, phase_next, exit_pulse, entry_pulse};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the gate lane sequencer core: directed cases, then random traffic.
module tb_top;
    import gls_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    // One request: dist_cm[0] is sensor one in the lowest bits, now_ms on top.
    typedef struct packed {
        logic [TIME_W-1:0]                   now_ms;
        logic [SENSOR_COUNT-1:0][DIST_W-1:0] dist_cm;
    } lane_req_t;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0] active_mask;
        logic                    exit_sensor_locked;
        logic [2:0]              lane_phase;
        logic [PULSE_W-1:0]      exit_pulse;
        logic [PULSE_W-1:0]      entry_pulse;
    } lane_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // dist_entry, dist_inside, dist_before_exit, dist_exit, now_ms
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // entry_pulse, exit_pulse, lane_phase, exit_sensor_locked, active_mask
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    gate_lane_sequencer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Lane controller copy: configuration and state.
    logic [DIST_W-1:0]  thr_q          = RST_DIST_THRESHOLD;
    logic [COUNT_W-1:0] confirm_q      = RST_CONFIRM_COUNT;
    logic [TIME_W-1:0]  lane_to_q      = RST_LANE_TIMEOUT;
    logic [TIME_W-1:0]  settle_q       = RST_EXIT_SETTLE;
    logic [PULSE_W-1:0] pulse_closed_q = RST_PULSE_CLOSED;
    logic [PULSE_W-1:0] pulse_open_q   = RST_PULSE_OPEN;
    phase_t             phase_q        = PHASE_IDLE;
    logic [TIME_W-1:0]  phase_t0       = '0;
    logic [COUNT_W-1:0] cnt_q [SENSOR_COUNT] = '{default: '0};
    logic               lock_q         = 1'b0;
    logic               entry_open_q   = 1'b0;
    logic               exit_open_q    = 1'b0;

    lane_result_t gate_outputs_due[$];
    lane_result_t got_res;
    lane_result_t want_res;
    int           fail_count = 0;

    logic [TIME_W-1:0] now_tick   = '0;
    int                burst_left = 0;
    bit                gaps_on    = 1'b0;
    int                stall_mode = RX_ALWAYS;
    int                hold_left  = 0;
    int unsigned       rx_cycle   = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic lane_result_t compute_gate_outputs(input lane_req_t req);
        logic [SENSOR_COUNT-1:0] act;
        logic [TIME_W-1:0]       elapsed;
        lane_result_t            res;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (req.dist_cm[i] != 0 && req.dist_cm[i] <= thr_q)
            begin
                if (cnt_q[i] < confirm_q)
                    cnt_q[i] = cnt_q[i] + 1'b1;
            end
            else
                cnt_q[i] = '0;
            act[i] = (cnt_q[i] >= confirm_q);
        end
        elapsed = req.now_ms - phase_t0;
        case (phase_q)
            PHASE_ENTRY_OPEN:
            begin
                if (act[1])
                begin
                    entry_open_q = 1'b0;
                    phase_q      = PHASE_ENTRY_CLOSED;
                    phase_t0     = req.now_ms;
                end
                else if (elapsed > lane_to_q)
                begin
                    entry_open_q = 1'b0;
                    lock_q       = 1'b0;
                    phase_q      = PHASE_IDLE;
                end
            end
            PHASE_ENTRY_CLOSED:
            begin
                if (act[2])
                begin
                    exit_open_q = 1'b1;
                    lock_q      = 1'b0;
                    phase_q     = PHASE_EXIT_OPEN;
                    phase_t0    = req.now_ms;
                end
                else if (elapsed > lane_to_q)
                begin
                    lock_q  = 1'b0;
                    phase_q = PHASE_IDLE;
                end
            end
            PHASE_EXIT_OPEN:
            begin
                if (!lock_q && act[3])
                begin
                    exit_open_q = 1'b0;
                    phase_q     = PHASE_EXIT_CLOSED;
                    phase_t0    = req.now_ms;
                end
                else if (elapsed > lane_to_q)
                begin
                    exit_open_q = 1'b0;
                    phase_q     = PHASE_IDLE;
                end
            end
            PHASE_EXIT_CLOSED:
            begin
                // Leaves as soon as sensor four drops, or when the settle time runs out.
                if (!act[3] || elapsed > settle_q)
                    phase_q = PHASE_IDLE;
            end
            default:
            begin
                if (act[0])
                begin
                    entry_open_q = 1'b1;
                    lock_q       = 1'b1;
                    phase_q      = PHASE_ENTRY_OPEN;
                    phase_t0     = req.now_ms;
                end
                else
                    phase_q = PHASE_IDLE;
            end
        endcase
        res.entry_pulse        = entry_open_q ? pulse_open_q : pulse_closed_q;
        res.exit_pulse         = exit_open_q ? pulse_open_q : pulse_closed_q;
        res.lane_phase         = phase_q;
        res.exit_sensor_locked = lock_q;
        res.active_mask        = act;
        return res;
    endfunction

    function automatic lane_req_t make_req(input logic [DIST_W-1:0] d0, input logic [DIST_W-1:0] d1,
                                           input logic [DIST_W-1:0] d2, input logic [DIST_W-1:0] d3,
                                           input logic [TIME_W-1:0] t);
        lane_req_t req;
        req.dist_cm[0] = d0;
        req.dist_cm[1] = d1;
        req.dist_cm[2] = d2;
        req.dist_cm[3] = d3;
        req.now_ms     = t;
        return req;
    endfunction

    function automatic logic [DIST_W-1:0] near_dist();
        if (thr_q == 0)
            return 16'd1;
        return DIST_W'($urandom_range(1, int'(thr_q)));
    endfunction

    function automatic logic [DIST_W-1:0] far_dist();
        if (thr_q == 16'hFFFF || $urandom_range(0, 1) == 0)
            return '0;
        return DIST_W'($urandom_range(int'(thr_q) + 1, 65535));
    endfunction

    function automatic logic [TIME_W-1:0] tick_step(input int unsigned step_max);
        if ($urandom_range(0, 99) < 3)
            return $urandom;
        return $urandom_range(0, step_max);
    endfunction

    // Receiver: a long hold-off when asked, otherwise the current stall pattern.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            case (stall_mode)
                RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) < 60);
                RX_PERIODIC: m_axis_tready <= ((rx_cycle % 13) < 8);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = m_axis_tdata;
            if (gate_outputs_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %h with no request pending", m_axis_tdata);
            end
            else
            begin
                want_res = gate_outputs_due.pop_front();
                if (got_res.entry_pulse !== want_res.entry_pulse
                    || got_res.exit_pulse !== want_res.exit_pulse
                    || got_res.lane_phase !== want_res.lane_phase
                    || got_res.exit_sensor_locked !== want_res.exit_sensor_locked
                    || got_res.active_mask !== want_res.active_mask)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: entry %0d/%0d exit %0d/%0d phase %0d/%0d lock %0d/%0d mask %h/%h (exp/got)",
                                 want_res.entry_pulse, got_res.entry_pulse,
                                 want_res.exit_pulse, got_res.exit_pulse,
                                 want_res.lane_phase, got_res.lane_phase,
                                 want_res.exit_sensor_locked, got_res.exit_sensor_locked,
                                 want_res.active_mask, got_res.active_mask);
                end
            end
        end
    end

    task automatic send_request(input lane_req_t req);
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
            end
            else
                burst_left--;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gate_outputs_due.push_back(compute_gate_outputs(req));
    endtask

    // Drops the request valid and waits until every pending result is back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (gate_outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_DIST_THRESHOLD: thr_q          = val[DIST_W-1:0];
            CFG_CONFIRM_COUNT:  confirm_q      = val[COUNT_W-1:0];
            CFG_LANE_TIMEOUT:   lane_to_q      = val;
            CFG_EXIT_SETTLE:    settle_q       = val;
            CFG_PULSE_CLOSED:   pulse_closed_q = val[PULSE_W-1:0];
            CFG_PULSE_OPEN:     pulse_open_q   = val[PULSE_W-1:0];
            default: ;
        endcase
        if (last)
            cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] cc,
                                 input logic [CFG_DATA_W-1:0] lane_to,
                                 input logic [CFG_DATA_W-1:0] settle,
                                 input logic [CFG_DATA_W-1:0] p_closed,
                                 input logic [CFG_DATA_W-1:0] p_open);
        wait_idle();
        write_reg(CFG_DIST_THRESHOLD, thr, 1'b0);
        write_reg(CFG_CONFIRM_COUNT, cc, 1'b0);
        write_reg(CFG_LANE_TIMEOUT, lane_to, 1'b0);
        write_reg(CFG_EXIT_SETTLE, settle, 1'b0);
        write_reg(CFG_PULSE_CLOSED, p_closed, 1'b0);
        write_reg(CFG_PULSE_OPEN, p_open, 1'b1);
    endtask

    // Reset configuration: field extremes, the threshold edge, and a first gate opening.
    task automatic test_field_extremes();
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
        send_request(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(16'd20, 16'd21, 16'd20, 16'd20, 32'd100));
        send_request(make_req(16'd20, 16'd20, 16'd20, 16'd20, 32'd200));
        send_request(make_req(16'd20, 16'd20, 16'd20, 16'd20, 32'd300));
        send_request(make_req(16'd1, 16'd1, 16'd1, 16'd1, 32'd400));
    endtask

    // Writes to the spare indexes must change nothing; then the registers at extremes, with a confirm count of one.
    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF, 1'b0);
        write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF, 1'b1);
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'd410));
        apply_setting(32'hFFFF, 32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF);
        send_request(make_req(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 32'd500));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'hFFFF, 32'd500));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'hFFFF, 32'd500));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd1, 32'd501));
        send_request(make_req(16'd1, 16'd0, 16'd0, 16'd0, 32'd502));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'd503));
    endtask

    // With a confirm count of zero every sensor reads active, even with no reading.
    task automatic test_confirm_zero();
        wait_idle();
        write_reg(CFG_CONFIRM_COUNT, 32'd0, 1'b1);
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'd600));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'd600));
    endtask

    // A counter above a lowered confirm count keeps its sensor active until a miss.
    task automatic test_confirm_lowered();
        wait_idle();
        write_reg(CFG_CONFIRM_COUNT, 32'd3, 1'b1);
        send_request(make_req(16'd0, 16'd5, 16'd0, 16'd0, 32'd700));
        send_request(make_req(16'd0, 16'd5, 16'd0, 16'd0, 32'd701));
        send_request(make_req(16'd0, 16'd5, 16'd0, 16'd0, 32'd702));
        wait_idle();
        write_reg(CFG_CONFIRM_COUNT, 32'd1, 1'b1);
        send_request(make_req(16'd0, 16'd5, 16'd0, 16'd0, 32'd703));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'd704));
    endtask

    // Elapsed time across the 32-bit tick wrap.
    task automatic test_tick_wrap();
        wait_idle();
        write_reg(CFG_LANE_TIMEOUT, 32'd100, 1'b1);
        send_request(make_req(16'd7, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFC0));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0010));
        send_request(make_req(16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0030));
    endtask

    task automatic run_lane_traffic(input int n_items, input int unsigned step_max);
        int        sent;
        int        len;
        lane_req_t req;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // A vehicle passing the four sensors in turn, then leaving the lane.
                for (int stage = 0; stage < 5 && sent < n_items; stage++)
                begin
                    len = $urandom_range(1, int'(confirm_q) + 2);
                    for (int k = 0; k < len && sent < n_items; k++)
                    begin
                        for (int i = 0; i < SENSOR_COUNT; i++)
                            req.dist_cm[i] = (i == stage || $urandom_range(0, 99) < 12)
                                             ? near_dist() : far_dist();
                        now_tick += tick_step(step_max);
                        req.now_ms = now_tick;
                        send_request(req);
                        sent++;
                    end
                end
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len && sent < n_items; k++)
                begin
                    for (int i = 0; i < SENSOR_COUNT; i++)
                    begin
                        case ($urandom_range(0, 3))
                            0:       req.dist_cm[i] = '0;
                            1:       req.dist_cm[i] = 16'hFFFF;
                            default: req.dist_cm[i] = DIST_W'($urandom);
                        endcase
                    end
                    if ($urandom_range(0, 9) == 0)
                        now_tick = $urandom;
                    else
                        now_tick += tick_step(step_max);
                    req.now_ms = now_tick;
                    send_request(req);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        apply_setting(32'd20, 32'd3, 32'd5000, 32'd3000, 32'd500, 32'd1500);
        gaps_on = 1'b1;
        stall_mode = RX_RANDOM;
        run_lane_traffic(175, 400);

        apply_setting(32'hFFFF, 32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF);
        gaps_on = 1'b0;
        stall_mode = RX_ALWAYS;
        run_lane_traffic(175, 3);

        apply_setting(32'd300, 32'd2, 32'd800, 32'd400, 32'd1000, 32'd2000);
        now_tick = 32'hFFFF_F000;
        gaps_on = 1'b1;
        stall_mode = RX_PERIODIC;
        run_lane_traffic(175, 150);

        apply_setting(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'd0);
        gaps_on = 1'b1;
        stall_mode = RX_ALWAYS;
        run_lane_traffic(125, 500);

        apply_setting(32'd1000, 32'd255, 32'd20000, 32'd1000, 32'd700, 32'd1700);
        gaps_on = 1'b0;
        stall_mode = RX_RANDOM;
        run_lane_traffic(175, 100);

        apply_setting($urandom_range(1, 500), $urandom_range(1, 4), $urandom_range(100, 3000),
                      $urandom_range(100, 3000), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        gaps_on = 1'b1;
        stall_mode = RX_RANDOM;
        run_lane_traffic(175, 300);
    endtask

    // The receiver holds off for a long stretch while requests keep coming back to back.
    task automatic test_backpressure();
        apply_setting(32'd50, 32'd2, 32'd2000, 32'd1000, 32'd600, 32'd2400);
        gaps_on = 1'b0;
        stall_mode = RX_ALWAYS;
        hold_left = 300;
        run_lane_traffic(50, 200);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_mode = RX_PERIODIC;
        test_field_extremes();
        test_register_extremes();
        test_confirm_zero();
        test_confirm_lowered();
        test_tick_wrap();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/gls_pkg.sv
hw/rtl/gate_lane_sequencer_core.sv
tb/tb_top.sv
